// ===== hdl/sca_pkg.sv =====
package sca_pkg;

   // field widths
   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 16;
   localparam int LEN_W     = 12;
   localparam int ADD_W     = 16;
   localparam int TOTAL_W   = 17;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // item kinds carried on req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   // calendar constants
   localparam logic [LEN_W-1:0]   DAY_LENGTH_RESET = 12'd960;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W:0]   MONTH_LAST = 5'd12;
   localparam logic [DAY_W:0]     DAY_MAX    = 6'd31;
   localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } sca_date_type;

   typedef enum logic {
      SCA_IDLE,
      SCA_RUN
   } sca_state_type;

   // days in a month; months outside 1..12 count as 31 days
   function automatic logic [DAY_W:0] month_length(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W:0] len;
      len = 6'd31;
      case (m) inside
         MONTH_FEB:                               len = leap ? 6'd29 : 6'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 6'd30;
         default:                                 len = 6'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== hdl/sca_fold_unit.sv =====
module sca_fold_unit (
   input  logic [sca_pkg::TOTAL_W-1:0] total,
   input  logic [sca_pkg::LEN_W-1:0]   day_length,
   output logic                        over,
   output logic [sca_pkg::TOTAL_W-1:0] diff
);
   import sca_pkg::*;

   logic [TOTAL_W-1:0] eff_len;

   // a zero day length acts as one minute
   assign eff_len = (day_length == '0) ? TOTAL_W'(1)
                                       : {{(TOTAL_W-LEN_W){1'b0}}, day_length};

   // shared compare and subtract, one day folded per use
   assign over = total > eff_len;
   assign diff = total - eff_len;

endmodule

// ===== hdl/sca_date_step.sv =====
module sca_date_step (
   input  sca_pkg::sca_date_type cur,
   output sca_pkg::sca_date_type nxt
);
   import sca_pkg::*;

   logic [DAY_W:0]   day_inc;
   logic [DAY_W:0]   mlen;
   logic             roll_month;
   logic [MONTH_W:0] month_inc;

   // next day and month rollover
   always_comb begin
      day_inc    = {1'b0, cur.day} + 6'd1;
      mlen       = month_length(cur.month, cur.year[1:0] == 2'b00);
      roll_month = (day_inc > mlen) || (day_inc > DAY_MAX);
      month_inc  = roll_month ? ({1'b0, cur.month} + 5'd1) : {1'b0, cur.month};

      nxt.day = roll_month ? DAY_FIRST : day_inc[DAY_W-1:0];
      // any month past december (also a loaded out-of-range one) goes to next year
      if (month_inc > MONTH_LAST) begin
         nxt.month = MONTH_JAN;
         nxt.year  = cur.year + 16'd1;
      end else begin
         nxt.month = month_inc[MONTH_W-1:0];
         nxt.year  = cur.year;
      end
   end

endmodule

// ===== hdl/shift_calendar_advance.sv =====
// Working-day calendar counter.
// Items arrive on the req_ stream: req_tuser selects a load (0) or an add (1).
// A load sets day, month and year and clears the minute count; an add adds
// req minutes and then folds whole working days out of the count, advancing
// the date one day per fold. Every item gives exactly one beat on rsp_ with
// the date and leftover minutes after it.
// After an item is accepted, the run state folds one day per cycle through
// the single compare-and-subtract unit, N days in all (none for a load),
// N = ceil((minutes + add - len) / len) when positive, len being the
// working-day length (0 counts as 1). With the 960 minute default N is at
// most 69; with a length of 1 it can reach about 69600. The result beat is
// then registered once the output is free. A new item is taken only after
// the result of the last one has been posted.
// req_tready is high only while the block is idle, one item at a time.
// The result sits in an output register; a stalled receiver holds the next
// result back in the folding state but the previous beat stays stable.
// csr_wr_en writes the day length at once; write it only while idle.
// Reset (synchronous, active high): date 1/1/0, minutes 0, day length 960.
module shift_calendar_advance (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // load_day[4:0], load_month[8:5], load_year[24:9], add_minutes[40:25]
   input  logic [sca_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op[0]
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // day[4:0], month[8:5], year[24:9], minutes_into_day[36:25]
   output logic [sca_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [sca_pkg::LEN_W-1:0]       csr_wr_data
);
   import sca_pkg::*;

   sca_state_type           state_ff, state_in;
   sca_date_type            date_ff, date_in, date_next;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    fold_over;
   logic [TOTAL_W-1:0]      fold_diff;
   logic                    out_free;
   logic                    accept;
   sca_date_type            load_date;
   logic [ADD_W-1:0]        add_minutes;

   // request field unpacking
   assign load_date.day   = req_tdata[4:0];
   assign load_date.month = req_tdata[8:5];
   assign load_date.year  = req_tdata[24:9];
   assign add_minutes     = req_tdata[40:25];

   sca_fold_unit u_fold (
      .total      (total_ff),
      .day_length (len_ff),
      .over       (fold_over),
      .diff       (fold_diff)
   );

   sca_date_step u_step (
      .cur (date_ff),
      .nxt (date_next)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == SCA_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer: accept, fold days, then post the result
   always_comb begin
      state_in     = state_ff;
      date_in      = date_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      len_in       = csr_wr_en ? csr_wr_data : len_ff;

      unique case (state_ff)
         SCA_IDLE: begin
            if (accept) begin
               state_in = SCA_RUN;
               if (req_tuser[0] == OP_LOAD) begin
                  date_in  = load_date;
                  total_in = '0;
               end else begin
                  total_in = total_ff + {{(TOTAL_W-ADD_W){1'b0}}, add_minutes};
               end
            end
         end
         SCA_RUN: begin
            if (fold_over) begin
               total_in = fold_diff;
               date_in  = date_next;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-37){1'b0}}, total_ff[LEN_W-1:0],
                               date_ff.year, date_ff.month, date_ff.day};
               state_in     = SCA_IDLE;
            end
         end
         default: state_in = SCA_IDLE;
      endcase
   end

   // control and calendar state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SCA_IDLE;
         rsp_valid_ff  <= 1'b0;
         len_ff        <= DAY_LENGTH_RESET;
         date_ff.day   <= DAY_FIRST;
         date_ff.month <= MONTH_JAN;
         date_ff.year  <= '0;
         total_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         date_ff      <= date_in;
         total_ff     <= total_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
